// ===== rtl/pdx_pkg.sv =====
// Shared constants and types for the packet deframer with XOR checksum.
// No dependencies; imported by pdx_parser and packet_deframer_xor_checksum.

package pdx_pkg;

	localparam int MAX_PAYLOAD    = 32;
	localparam int RESERVED_BYTES = 23;
	localparam int HDR_LEN        = 7;

	// position counts up to the high checksum byte
	localparam int POS_MAX = HDR_LEN + MAX_PAYLOAD + RESERVED_BYTES + 1;
	localparam int POS_W   = $clog2(POS_MAX + 1);
	localparam int LEN_W   = $clog2(MAX_PAYLOAD + 1);
	localparam int IDX_W   = 5;

	// header byte offsets
	localparam logic [POS_W-1:0] POS_DEST    = POS_W'(0);
	localparam logic [POS_W-1:0] POS_SRC     = POS_W'(1);
	localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(2);
	localparam logic [POS_W-1:0] POS_SIZE_LO = POS_W'(3);
	localparam logic [POS_W-1:0] POS_SIZE_HI = POS_W'(4);
	localparam logic [POS_W-1:0] POS_CNT_LO  = POS_W'(5);
	localparam logic [POS_W-1:0] POS_CNT_HI  = POS_W'(6);

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_RESERVED = 2'd1,
		KIND_DONE     = 2'd2
	} kind_t;

	typedef struct packed {
		logic [15:0]      computed_checksum;
		logic [15:0]      received_checksum;
		logic [15:0]      sent_count;
		logic [15:0]      total_size;
		logic [7:0]       frame_type;
		logic [7:0]       src_address;
		logic [7:0]       dest_address;
		logic [IDX_W-1:0] byte_index;
		logic [7:0]       byte_value;
		kind_t            kind;
	} result_t;

endpackage

// ===== rtl/pdx_parser.sv =====
// Frame parser: position counter, header hold registers and XOR accumulator.
// Depends on pdx_pkg. Produces the result for the byte at its input combinationally.

module pdx_parser
	import pdx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] rx_byte,
	output logic       has_result,
	output result_t    res
);

	logic [POS_W-1:0] position_q;
	logic [7:0]       dest_q;
	logic [7:0]       src_q;
	logic [7:0]       type_q;
	logic [15:0]      size_q;
	logic [15:0]      count_q;
	logic [LEN_W-1:0] pay_len_q;
	logic [15:0]      xor_q;
	logic [7:0]       cks_lo_q;

	logic [POS_W-1:0] pay_end;
	logic [POS_W-1:0] res_end;
	logic             in_hdr;
	logic             in_pay;
	logic             in_res;
	logic             at_cks_lo;
	logic             at_cks_hi;
	logic [15:0]      count_new;
	logic [16:0]      diff;
	logic [LEN_W-1:0] len_new;

	assign pay_end   = POS_W'(HDR_LEN) + POS_W'(pay_len_q);
	assign res_end   = pay_end + POS_W'(RESERVED_BYTES);
	assign in_hdr    = position_q < POS_W'(HDR_LEN);
	assign in_pay    = !in_hdr && (position_q < pay_end);
	assign in_res    = !in_hdr && !in_pay && (position_q < res_end);
	assign at_cks_lo = !in_hdr && !in_pay && !in_res && (position_q == res_end);
	assign at_cks_hi = !in_hdr && !in_pay && !in_res && !at_cks_lo;

	// clamp size - counter to 0..MAX_PAYLOAD using the counter as it completes
	assign count_new = {rx_byte, count_q[7:0]};
	assign diff      = {1'b0, size_q} - {1'b0, count_new};
	always_comb begin
		if (count_new >= size_q) begin
			len_new = '0;
		end else if (diff > 17'(MAX_PAYLOAD)) begin
			len_new = LEN_W'(MAX_PAYLOAD);
		end else begin
			len_new = diff[LEN_W-1:0];
		end
	end

	assign has_result = in_pay || in_res || at_cks_hi;

	always_comb begin
		res = '0;
		if (in_pay) begin
			res.kind       = KIND_PAYLOAD;
			res.byte_value = rx_byte;
			res.byte_index = IDX_W'(position_q - POS_W'(HDR_LEN));
		end else if (in_res) begin
			res.kind       = KIND_RESERVED;
			res.byte_value = rx_byte;
			res.byte_index = IDX_W'(position_q - pay_end);
		end else if (at_cks_hi) begin
			res.kind              = KIND_DONE;
			res.dest_address      = dest_q;
			res.src_address       = src_q;
			res.frame_type        = type_q;
			res.total_size        = size_q;
			res.sent_count        = count_q;
			res.received_checksum = {rx_byte, cks_lo_q};
			res.computed_checksum = xor_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			dest_q     <= '0;
			src_q      <= '0;
			type_q     <= '0;
			size_q     <= '0;
			count_q    <= '0;
			pay_len_q  <= '0;
			xor_q      <= '0;
			cks_lo_q   <= '0;
		end else if (advance) begin
			// frame done: restart at the first header byte
			if (at_cks_hi) begin
				position_q <= '0;
			end else begin
				position_q <= position_q + POS_W'(1);
			end
			if (in_hdr) begin
				unique case (position_q)
					POS_DEST:    dest_q         <= rx_byte;
					POS_SRC:     src_q          <= rx_byte;
					POS_TYPE:    type_q         <= rx_byte;
					POS_SIZE_LO: size_q[7:0]    <= rx_byte;
					POS_SIZE_HI: size_q[15:8]   <= rx_byte;
					POS_CNT_LO:  count_q[7:0]   <= rx_byte;
					default: begin
						count_q[15:8] <= rx_byte;
						pay_len_q     <= len_new;
						xor_q         <= {8'h00, dest_q ^ src_q ^ type_q} ^ size_q ^ count_new;
					end
				endcase
			end
			if (in_pay) begin
				xor_q <= xor_q ^ {8'h00, rx_byte};
			end
			if (at_cks_lo) begin
				cks_lo_q <= rx_byte;
			end
		end
	end

endmodule

// ===== rtl/packet_deframer_xor_checksum.sv =====
// Top level of the packet deframer: input word register, parser, output register.
// Depends on pdx_pkg and pdx_parser.

// Accepts one frame word per clock and gives at most one output word per input
// word, valid once it has passed the input register and then the output register.
// Payload and reserved bytes come out with kind 0 or 1 and their index; after the
// high checksum byte one word with kind 2 carries the header fields, the received
// and the computed XOR checksum, and the next input word starts a new frame.
// Header bytes and the low checksum byte give no output word. Full rate holds
// while m_tready stays high; the output register lets a new word enter while a
// finished word waits.

module packet_deframer_xor_checksum
	import pdx_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] rx_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // [7:0] byte_value, [12:8] byte_index,
	                                // [20:13] dest_address, [28:21] src_address,
	                                // [36:29] frame_type, [52:37] total_size,
	                                // [68:53] sent_count, [84:69] received_checksum,
	                                // [100:85] computed_checksum, [103:101] zero
	output logic [1:0]   m_tuser    // [1:0] kind
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       has_result;
	result_t    res;
	logic       out_free;
	logic       adv_s1;
	result_t    out_q;
	logic       out_valid_q;

	assign out_free = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && (!has_result || out_free);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	pdx_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (adv_s1),
		.rx_byte    (byte_s1),
		.has_result (has_result),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the word until taken
	always_ff @(posedge clk) begin
		if (adv_s1 && has_result) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {3'b000,
	                   out_q.computed_checksum,
	                   out_q.received_checksum,
	                   out_q.sent_count,
	                   out_q.total_size,
	                   out_q.frame_type,
	                   out_q.src_address,
	                   out_q.dest_address,
	                   out_q.byte_index,
	                   out_q.byte_value};

endmodule

// ===== bench/packet_deframer_xor_checksum_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for packet_deframer_xor_checksum: drives framed byte streams,
// predicts every output word and compares it field by field. Depends on pdx_pkg.

module packet_deframer_xor_checksum_tb;
	import pdx_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'd0;   // [7:0] rx_byte
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;          // [7:0] byte_value, [12:8] byte_index, [20:13] dest,
	                                // [28:21] src, [36:29] type, [52:37] size,
	                                // [68:53] count, [84:69] rx sum, [100:85] xor sum
	logic [1:0]   m_tuser;          // [1:0] kind

	packet_deframer_xor_checksum i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [7:0] rx_stream[$];
	result_t    expected_words[$];
	int         mismatches = 0;
	int         tick = 0;

	// frame tracking of the predictor
	logic [6:0]  frame_pos = '0;
	logic [7:0]  got_dest = '0, got_src = '0, got_type = '0, sum_low = '0;
	logic [15:0] got_size = '0, got_count = '0, xor_sum = '0;
	logic [5:0]  body_len = '0;

	// no idling at all inside this window
	wire calm = (tick >= 300) && (tick < 800);

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	function automatic logic [5:0] clamped_length(input logic [15:0] size,
			input logic [15:0] count);
		logic [15:0] diff;
		if (count >= size)
			return '0;
		diff = size - count;
		return (diff > MAX_PAYLOAD) ? 6'(MAX_PAYLOAD) : diff[5:0];
	endfunction

	// advance the frame by one byte and queue the word it must produce
	task automatic deframe_byte(input logic [7:0] b);
		result_t    w;
		logic [6:0] pay_end;
		logic [6:0] res_end;
		w = '0;
		pay_end = 7'(HDR_LEN) + 7'(body_len);
		res_end = pay_end + 7'(RESERVED_BYTES);
		if (frame_pos < HDR_LEN) begin
			case (frame_pos)
				7'(POS_DEST):    got_dest = b;
				7'(POS_SRC):     got_src = b;
				7'(POS_TYPE):    got_type = b;
				7'(POS_SIZE_LO): got_size = {8'd0, b};
				7'(POS_SIZE_HI): got_size[15:8] = b;
				7'(POS_CNT_LO):  got_count = {8'd0, b};
				default: begin
					got_count[15:8] = b;
					body_len = clamped_length(got_size, got_count);
					xor_sum = {8'd0, got_dest ^ got_src ^ got_type} ^ got_size ^ got_count;
				end
			endcase
			frame_pos++;
		end else if (frame_pos < pay_end) begin
			xor_sum ^= {8'd0, b};
			w.kind = KIND_PAYLOAD;
			w.byte_value = b;
			w.byte_index = 5'(frame_pos - 7'(HDR_LEN));
			expected_words.push_back(w);
			frame_pos++;
		end else if (frame_pos < res_end) begin
			w.kind = KIND_RESERVED;
			w.byte_value = b;
			w.byte_index = 5'(frame_pos - pay_end);
			expected_words.push_back(w);
			frame_pos++;
		end else if (frame_pos == res_end) begin
			sum_low = b;
			frame_pos++;
		end else begin
			w.kind = KIND_DONE;
			w.dest_address = got_dest;
			w.src_address = got_src;
			w.frame_type = got_type;
			w.total_size = got_size;
			w.sent_count = got_count;
			w.received_checksum = {b, sum_low};
			w.computed_checksum = xor_sum;
			expected_words.push_back(w);
			frame_pos = '0;
			got_dest = '0;
			got_src = '0;
			got_type = '0;
			got_size = '0;
			got_count = '0;
			body_len = '0;
			xor_sum = '0;
			sum_low = '0;
		end
	endtask

	// queue one whole frame; body bytes are random unless a fill byte is forced
	task automatic add_frame(input logic [7:0] dest, input logic [7:0] src,
			input logic [7:0] ftype, input logic [15:0] size, input logic [15:0] count,
			input bit fixed_fill, input logic [7:0] fill);
		int n;
		n = int'(clamped_length(size, count)) + RESERVED_BYTES + 2;
		rx_stream.push_back(dest);
		rx_stream.push_back(src);
		rx_stream.push_back(ftype);
		rx_stream.push_back(size[7:0]);
		rx_stream.push_back(size[15:8]);
		rx_stream.push_back(count[7:0]);
		rx_stream.push_back(count[15:8]);
		for (int i = 0; i < n; i++)
			rx_stream.push_back(fixed_fill ? fill : 8'($urandom));
	endtask

	// driver: hold a word until taken, then load the next one or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'd0;
		end else begin
			tick <= tick + 1;
			if (s_tvalid && s_tready)
				deframe_byte(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (rx_stream.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
					s_tvalid <= 1'b1;
					s_tdata <= rx_stream.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each taken output word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = result_t'({m_tdata[100:0], m_tuser});
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word kind %0d", m_tuser));
				end else begin
					want = expected_words.pop_front();
					compare_field("kind", 16'(got.kind), 16'(want.kind));
					compare_field("byte_value", 16'(got.byte_value), 16'(want.byte_value));
					compare_field("byte_index", 16'(got.byte_index), 16'(want.byte_index));
					compare_field("dest_address", 16'(got.dest_address),
						16'(want.dest_address));
					compare_field("src_address", 16'(got.src_address), 16'(want.src_address));
					compare_field("frame_type", 16'(got.frame_type), 16'(want.frame_type));
					compare_field("total_size", got.total_size, want.total_size);
					compare_field("sent_count", got.sent_count, want.sent_count);
					compare_field("received_checksum", got.received_checksum,
						want.received_checksum);
					compare_field("computed_checksum", got.computed_checksum,
						want.computed_checksum);
				end
			end
			m_tready <= calm || ($urandom_range(0, 99) >= 7);
		end
	end

	initial begin
		logic [15:0] size;
		logic [15:0] count;
		int          pick;

		// directed frames: empty, saturated, counter above size, exact limits
		add_frame(8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'h00);
		add_frame(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'h0000, 1'b1, 8'hFF);
		add_frame(8'h01, 8'h80, 8'h7F, 16'h0005, 16'h0100, 1'b0, 8'h00);
		add_frame(8'hA5, 8'h5A, 8'hC3, 16'h1234, 16'h1214, 1'b0, 8'h00);
		add_frame(8'h3C, 8'hC3, 8'h00, 16'h0021, 16'h0000, 1'b0, 8'h00);
		add_frame(8'h12, 8'h34, 8'h56, 16'h8001, 16'h8000, 1'b0, 8'h00);
		add_frame(8'hFE, 8'h01, 8'hAA, 16'h0100, 16'h00E1, 1'b0, 8'h00);
		add_frame(8'h55, 8'hAA, 8'h80, 16'h0000, 16'hFFFF, 1'b1, 8'h55);

		while (rx_stream.size() < 1200) begin
			count = 16'($urandom);
			pick = $urandom_range(0, 9);
			if (pick < 6)
				size = count + 16'($urandom_range(0, 34));
			else if (pick < 8)
				size = count - 16'($urandom_range(1, 300));
			else
				size = 16'($urandom);
			add_frame(8'($urandom), 8'($urandom), 8'($urandom), size, count, 1'b0, 8'h00);
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (rx_stream.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#200000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
